// ===== rtl/csfr_pkg.sv =====
// Shared types and constants for the settings frame receiver.
`timescale 1ns / 1ps

package csfr_pkg;

  localparam logic [7:0] HeaderByte  = 8'hAA;
  localparam logic [3:0] CheckPos    = 4'd11;
  localparam logic [3:0] FieldFirst  = 4'd2;
  localparam int         FieldCount  = 9;
  localparam int         FieldIdxW   = $clog2(FieldCount);
  localparam int         GainBShift  = 6;

  typedef logic [3:0] frame_pos_t;
  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic  frame_ok;
    byte_t gain_a;
    byte_t gain_b;
    byte_t sink0_level;
    byte_t sink1_level;
    byte_t amp_delay;
    byte_t sink0_delay;
    byte_t sink1_delay;
    byte_t alarm_setting;
  } settings_t;

endpackage

// ===== rtl/csfr_if.sv =====
// Valid/ready channel interfaces for received bytes and decoded settings.
`timescale 1ns / 1ps

interface csfr_byte_if
  import csfr_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface csfr_result_if
  import csfr_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  frame_ok;
  byte_t gain_a;
  byte_t gain_b;
  byte_t sink0_level;
  byte_t sink1_level;
  byte_t amp_delay;
  byte_t sink0_delay;
  byte_t sink1_delay;
  byte_t alarm_setting;

  modport source (
    output valid, output frame_ok, output gain_a, output gain_b,
    output sink0_level, output sink1_level, output amp_delay,
    output sink0_delay, output sink1_delay, output alarm_setting,
    input ready
  );
  modport sink (
    input valid, input frame_ok, input gain_a, input gain_b,
    input sink0_level, input sink1_level, input amp_delay,
    input sink0_delay, input sink1_delay, input alarm_setting,
    output ready
  );
endinterface

// ===== rtl/csfr_assembler.sv =====
// Frame position tracking, running checksum, field capture and decode.
`timescale 1ns / 1ps

module csfr_assembler
  import csfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_accept,
  input  byte_t     rx_byte,
  output logic      res_valid,
  output settings_t res
);

  frame_pos_t position;
  frame_pos_t position_next;
  byte_t      running_sum;
  byte_t      running_sum_next;
  byte_t      field_store [FieldCount];
  frame_pos_t field_offset;
  logic [FieldIdxW-1:0] field_idx;
  logic       at_header;
  logic       in_body;
  logic       sum_match;

  assign at_header    = (position == 4'd0);
  assign in_body      = !at_header && (position < CheckPos);
  assign field_offset = position - FieldFirst;
  assign field_idx    = field_offset[FieldIdxW-1:0];
  assign sum_match    = (rx_byte == running_sum);
  assign res_valid    = byte_accept && !at_header && !in_body;

  always_comb begin
    position_next    = position;
    running_sum_next = running_sum;
    if (byte_accept) begin
      if (at_header) begin
        if (rx_byte == HeaderByte) begin
          position_next    = 4'd1;
          running_sum_next = rx_byte;
        end
      end else if (in_body) begin
        position_next    = position + 4'd1;
        running_sum_next = running_sum + rx_byte;
      end else begin
        position_next    = 4'd0;
        running_sum_next = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= 4'd0;
      running_sum <= 8'd0;
    end else begin
      position    <= position_next;
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept && in_body && (position >= FieldFirst)) begin
      field_store[field_idx] <= rx_byte;
    end
  end

  always_comb begin
    res = '0;
    if (sum_match) begin
      res.frame_ok      = 1'b1;
      res.gain_a        = field_store[0];
      res.gain_b        = field_store[1] + byte_t'(field_store[2] << GainBShift);
      res.sink0_level   = field_store[3];
      res.sink1_level   = field_store[4];
      res.amp_delay     = field_store[5];
      res.sink0_delay   = field_store[6];
      res.sink1_delay   = field_store[7];
      res.alarm_setting = field_store[8];
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= CheckPos)
    else $error("frame position beyond checksum byte");

  a_idle_sum_clear: assert property (@(posedge clk) disable iff (rst)
    at_header |-> running_sum == 8'd0)
    else $error("running sum not cleared between frames");

  a_result_restarts: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> at_header)
    else $error("position did not return to header after result");

  a_header_start: assert property (@(posedge clk) disable iff (rst)
    (at_header && byte_accept && rx_byte != HeaderByte) |=> at_header)
    else $error("bad header byte advanced the frame");

endmodule

// ===== rtl/csfr_out_stage.sv =====
// Output register with skid entry for decoded settings transactions.
`timescale 1ns / 1ps

module csfr_out_stage
  import csfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  settings_t load_data,
  output logic      load_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output settings_t out_data
);

  logic      skid_valid;
  settings_t skid_data;
  logic      out_fire;

  assign out_fire   = out_valid && out_ready;
  assign load_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid && out_fire) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else if (load) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && out_fire) begin
      out_data <= skid_data;
    end else if (load) begin
      if (!out_valid || out_fire) begin
        out_data <= load_data;
      end else begin
        skid_data <= load_data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output transaction");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(load && skid_valid))
    else $error("result loaded while skid entry full");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_fire) |=> (out_valid && !skid_valid))
    else $error("skid entry did not move to output");

endmodule

// ===== rtl/checksummed_settings_frame_receiver.sv =====
// Top level: settings frame receiver with additive checksum check.
//
// Usage:
//   rx  : byte channel (valid/ready). One received byte per transaction.
//   res : result channel (valid/ready). One transaction per completed frame,
//         issued when the checksum byte (frame byte 11) is taken. frame_ok
//         is 1 on a checksum match with the decoded settings; on a mismatch
//         frame_ok and all settings fields are 0.
//   A byte at frame position 0 other than 0xAA is dropped without result.
// Throughput: one byte per cycle, sustained while rx.ready is high.
// Output: the result is loaded into the output register when the checksum
//   byte is taken, or into the skid entry while res is stalled.
// Reset (rst, synchronous): frame position and running sum clear, output
//   and skid entries empty; rx.ready is high the cycle after reset.
// Stall: while res is stalled one further result fits in the skid entry;
//   rx.ready drops only when both output entries hold results.

`timescale 1ns / 1ps

module checksummed_settings_frame_receiver
  import csfr_pkg::*;
(
  input logic         clk,
  input logic         rst,
  csfr_byte_if.sink   rx,
  csfr_result_if.source res
);

  logic      byte_accept;
  logic      load_ready;
  logic      asm_valid;
  settings_t asm_res;
  settings_t out_data;

  assign rx.ready    = load_ready;
  assign byte_accept = rx.valid && load_ready;

  csfr_assembler u_assembler (
    .clk         (clk),
    .rst         (rst),
    .byte_accept (byte_accept),
    .rx_byte     (rx.rx_byte),
    .res_valid   (asm_valid),
    .res         (asm_res)
  );

  csfr_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (asm_valid),
    .load_data  (asm_res),
    .load_ready (load_ready),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_data   (out_data)
  );

  assign res.frame_ok      = out_data.frame_ok;
  assign res.gain_a        = out_data.gain_a;
  assign res.gain_b        = out_data.gain_b;
  assign res.sink0_level   = out_data.sink0_level;
  assign res.sink1_level   = out_data.sink1_level;
  assign res.amp_delay     = out_data.amp_delay;
  assign res.sink0_delay   = out_data.sink0_delay;
  assign res.sink1_delay   = out_data.sink1_delay;
  assign res.alarm_setting = out_data.alarm_setting;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the settings frame receiver: directed frames, then random byte streams.
`timescale 1ns / 1ps

module tb_top;
  import csfr_pkg::*;

  localparam int NumItems = 1300;
  localparam int DrainCycles = 20;
  localparam int TimeLimitNs = 1_000_000;

  typedef enum logic {RowJunk, RowFrame} row_kind_t;

  typedef struct {
    row_kind_t       kind;
    byte_t           lead;
    logic [9:0][7:0] body;
    byte_t           cks_err;
    logic            has_exp;
    settings_t       exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  csfr_byte_if   rx();
  csfr_result_if res();

  checksummed_settings_frame_receiver uut (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .res(res)
  );

  frame_pos_t pred_pos = '0;
  byte_t      pred_sum = '0;
  byte_t      pred_fields [FieldCount];

  settings_t  pending_settings [$];
  settings_t  pinned_settings [int];
  int         frames_predicted = 0;
  int         taken_bytes = 0;
  int         errors = 0;
  int         good_frames = 0;
  int         bad_frames = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(TimeLimitNs);
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic decode_byte(input byte_t b, output logic done, output settings_t s);
    s = '0;
    done = 1'b0;
    if (pred_pos == '0) begin
      if (b == HeaderByte) begin
        pred_sum = b;
        pred_pos = 4'd1;
      end
    end else if (pred_pos < CheckPos) begin
      pred_sum = pred_sum + b;
      if (pred_pos >= FieldFirst) begin
        pred_fields[pred_pos - FieldFirst] = b;
      end
      pred_pos = pred_pos + 4'd1;
    end else begin
      done = 1'b1;
      if (b == pred_sum) begin
        s.frame_ok      = 1'b1;
        s.gain_a        = pred_fields[0];
        s.gain_b        = pred_fields[1] + (pred_fields[2] << GainBShift);
        s.sink0_level   = pred_fields[3];
        s.sink1_level   = pred_fields[4];
        s.amp_delay     = pred_fields[5];
        s.sink0_delay   = pred_fields[6];
        s.sink1_delay   = pred_fields[7];
        s.alarm_setting = pred_fields[8];
      end
      pred_pos = '0;
      pred_sum = '0;
    end
  endtask

  always @(posedge clk) begin
    logic      done;
    settings_t s;
    if (!rst && rx.valid && rx.ready) begin
      if (pred_pos != '0 || rx.rx_byte == HeaderByte) begin
        taken_bytes++;
      end
      decode_byte(rx.rx_byte, done, s);
      if (done) begin
        if (pinned_settings.exists(frames_predicted)) begin
          s = pinned_settings[frames_predicted];
        end
        pending_settings.push_back(s);
        frames_predicted++;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    settings_t want;
    settings_t got;
    if (!rst && res.valid && res.ready) begin
      got = '{res.frame_ok, res.gain_a, res.gain_b, res.sink0_level, res.sink1_level,
              res.amp_delay, res.sink0_delay, res.sink1_delay, res.alarm_setting};
      if (pending_settings.size() == 0) begin
        errors++;
        $error("result transaction with no frame pending");
      end else begin
        want = pending_settings.pop_front();
        check_field("frame_ok", want.frame_ok, got.frame_ok);
        check_field("gain_a", want.gain_a, got.gain_a);
        check_field("gain_b", want.gain_b, got.gain_b);
        check_field("sink0_level", want.sink0_level, got.sink0_level);
        check_field("sink1_level", want.sink1_level, got.sink1_level);
        check_field("amp_delay", want.amp_delay, got.amp_delay);
        check_field("sink0_delay", want.sink0_delay, got.sink0_delay);
        check_field("sink1_delay", want.sink1_delay, got.sink1_delay);
        check_field("alarm_setting", want.alarm_setting, got.alarm_setting);
        if (got.frame_ok) begin
          good_frames++;
        end else begin
          bad_frames++;
        end
      end
    end
  end

  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_byte(input byte_t b);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
  endtask

  task automatic send_frame(input logic [9:0][7:0] body, input byte_t cks_err);
    byte_t sum;
    sum = HeaderByte;
    push_byte(HeaderByte);
    for (int i = 0; i < 10; i++) begin
      sum = sum + body[i];
      push_byte(body[i]);
    end
    push_byte(sum + cks_err);
  endtask

  initial begin
    stim_row_t       rows [4];
    logic [9:0][7:0] body;
    int              frame_idx;
    int              pick;
    byte_t           cks_err;

    rst        <= 1'b1;
    rx.valid   <= 1'b0;
    rx.rx_byte <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    rows[0] = '{RowJunk, 8'h00, '0, 8'h00, 1'b0, '0};
    rows[1] = '{RowJunk, 8'h55, '0, 8'h00, 1'b0, '0};
    rows[2] = '{RowFrame, HeaderByte, {10{8'hFF}}, 8'h00, 1'b1,
                '{1'b1, 8'hFF, 8'hBF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}};
    rows[3] = '{RowFrame, HeaderByte, '0, 8'h01, 1'b1, '0};

    frame_idx = 0;
    foreach (rows[r]) begin
      if (rows[r].kind == RowJunk) begin
        push_byte(rows[r].lead);
      end else begin
        if (rows[r].has_exp) begin
          pinned_settings[frame_idx] = rows[r].exp;
        end
        send_frame(rows[r].body, rows[r].cks_err);
        frame_idx++;
      end
    end

    while (taken_bytes < NumItems) begin
      case (taken_bytes * 4 / NumItems)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      pick = $urandom_range(99);
      if (pick < 80) begin
        for (int i = 0; i < 10; i++) begin
          body[i] = byte_t'($urandom_range(255));
        end
        cks_err = ($urandom_range(3) == 0) ? byte_t'($urandom_range(255, 1)) : 8'h00;
        send_frame(body, cks_err);
      end else if (pick < 90) begin
        push_byte(byte_t'($urandom_range(255)));
      end else begin
        push_byte(HeaderByte);
        repeat ($urandom_range(9)) push_byte(byte_t'($urandom_range(255)));
      end
    end

    rx.valid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk);
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Streamed %0d frame bytes plus header noise under four pacing phases;",
             taken_bytes);
    $display("checked %0d accepted and %0d rejected frames.", good_frames, bad_frames);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/csfr_pkg.sv
rtl/csfr_if.sv
rtl/csfr_assembler.sv
rtl/csfr_out_stage.sv
rtl/checksummed_settings_frame_receiver.sv
bench/tb_top.sv
